// ===== hdl/lei_pkg.sv =====
// Shared types and constants for the length-encoded integer decoder.
`timescale 1ns / 1ps

package lei_pkg;

    localparam logic [7:0] PREFIX_NULL = 8'd251;
    localparam logic [7:0] PREFIX_2    = 8'd252;
    localparam logic [7:0] PREFIX_3    = 8'd253;
    localparam logic [7:0] PREFIX_8    = 8'd254;
    localparam logic [7:0] PREFIX_ERR  = 8'd255;

    localparam logic [3:0] NEED_2 = 4'd2;
    localparam logic [3:0] NEED_3 = 4'd3;
    localparam logic [3:0] NEED_8 = 4'd8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NULL  = 2'd1,
        ST_ERR   = 2'd2,
        ST_TRUNC = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
    } t_byte_item;

    typedef struct packed {
        logic       valid;
        t_byte_item item;
    } t_stage;

    typedef struct packed {
        logic [63:0] value;
        t_status     status;
        logic [3:0]  encoded_length;
    } t_result;

endpackage

// ===== hdl/lei_if.sv =====
// Valid/ready channel interfaces for packet bytes and decoded integers.
`timescale 1ns / 1ps

interface lei_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_end;

    modport source (output valid, data_byte, packet_end, input ready);
    modport sink (input valid, data_byte, packet_end, output ready);
endinterface

interface lei_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;
    logic [3:0]  encoded_length;

    modport source (output valid, value, status, encoded_length, input ready);
    modport sink (input valid, value, status, encoded_length, output ready);
endinterface

// ===== hdl/lei_in_stage.sv =====
// Input register that holds one packet byte for the decoder.
`timescale 1ns / 1ps

module lei_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lei_byte_if.sink        i_in_chan,
    input  logic            i_take,
    output lei_pkg::t_stage o_stage
);

    logic                r_valid;
    logic                n_valid;
    lei_pkg::t_byte_item r_item;
    logic                w_accept;

    assign i_in_chan.ready = !r_valid || i_take;
    assign w_accept        = i_in_chan.valid && i_in_chan.ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.data_byte  <= i_in_chan.data_byte;
            r_item.packet_end <= i_in_chan.packet_end;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// ===== hdl/lei_core.sv =====
// Decode state, per-byte decode logic and the result register.
`timescale 1ns / 1ps

module lei_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lei_pkg::t_stage i_stage,
    output logic            o_take,
    lei_result_if.source    o_out_chan
);

    logic [3:0]       r_rem;
    logic [63:0]      r_acc;
    logic [2:0]       r_pos;
    logic [3:0]       r_total;
    logic [3:0]       n_rem;
    logic [63:0]      n_acc;
    logic [2:0]       n_pos;
    logic [3:0]       n_total;

    logic             r_out_valid;
    lei_pkg::t_result r_res;
    lei_pkg::t_result w_res;
    logic             w_emit;
    logic [7:0]       w_byte;
    logic             w_last;
    logic [63:0]      w_merged;
    logic [3:0]       w_rem_dec;
    logic [3:0]       w_total_inc;
    logic [3:0]       w_need;

    assign w_byte = i_stage.item.data_byte;
    assign w_last = i_stage.item.packet_end;
    assign o_take = i_stage.valid && (!r_out_valid || o_out_chan.ready);

    always_comb begin
        unique case (w_byte)
            lei_pkg::PREFIX_2: w_need = lei_pkg::NEED_2;
            lei_pkg::PREFIX_3: w_need = lei_pkg::NEED_3;
            default:           w_need = lei_pkg::NEED_8;
        endcase
    end

    always_comb begin
        w_merged = r_acc;
        for (int k = 0; k < 8; k++) begin
            if (r_pos == 3'(k)) begin
                w_merged[8*k +: 8] = r_acc[8*k +: 8] | w_byte;
            end
        end
    end

    assign w_rem_dec   = r_rem - 4'd1;
    assign w_total_inc = r_total + 4'd1;

    always_comb begin
        n_rem                = r_rem;
        n_acc                = r_acc;
        n_pos                = r_pos;
        n_total              = r_total;
        w_emit               = 1'b0;
        w_res.value          = 64'd0;
        w_res.status         = lei_pkg::ST_OK;
        w_res.encoded_length = 4'd1;
        if (r_rem == 4'd0) begin
            priority if (w_byte < lei_pkg::PREFIX_NULL) begin
                w_emit      = 1'b1;
                w_res.value = {56'd0, w_byte};
            end else if (w_byte == lei_pkg::PREFIX_NULL) begin
                w_emit       = 1'b1;
                w_res.status = lei_pkg::ST_NULL;
            end else if (w_byte == lei_pkg::PREFIX_ERR) begin
                w_emit       = 1'b1;
                w_res.status = lei_pkg::ST_ERR;
            end else if (w_last) begin
                w_emit       = 1'b1;
                w_res.status = lei_pkg::ST_TRUNC;
            end else begin
                n_rem   = w_need;
                n_acc   = 64'd0;
                n_pos   = 3'd0;
                n_total = 4'd1;
            end
        end else begin
            if (w_rem_dec == 4'd0) begin
                w_emit               = 1'b1;
                w_res.value          = w_merged;
                w_res.encoded_length = w_total_inc;
            end else if (w_last) begin
                w_emit               = 1'b1;
                w_res.status         = lei_pkg::ST_TRUNC;
                w_res.encoded_length = w_total_inc;
            end
            if (w_emit) begin
                n_rem   = 4'd0;
                n_acc   = 64'd0;
                n_pos   = 3'd0;
                n_total = 4'd0;
            end else begin
                n_rem   = w_rem_dec;
                n_acc   = w_merged;
                n_pos   = r_pos + 3'd1;
                n_total = w_total_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= 4'd0;
            r_acc       <= 64'd0;
            r_pos       <= 3'd0;
            r_total     <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_rem   <= n_rem;
                r_acc   <= n_acc;
                r_pos   <= n_pos;
                r_total <= n_total;
            end
            if (o_take && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_emit) begin
            r_res <= w_res;
        end
    end

    assign o_out_chan.valid          = r_out_valid;
    assign o_out_chan.value          = r_res.value;
    assign o_out_chan.status         = r_res.status;
    assign o_out_chan.encoded_length = r_res.encoded_length;

endmodule

// ===== hdl/length_encoded_int_decoder_top.sv =====
// Top level of the length-encoded integer decoder.
`timescale 1ns / 1ps

// The decoder takes one packet byte per cycle and parses the stream as back-to-back
// length-encoded integers. Each byte passes an input register and then the decode logic,
// which loads a result register, so a result is offered from the result register once
// the byte that completes its integer has passed the input register and the decode logic.
// Bytes that complete nothing produce no transaction. A new byte can be accepted every
// cycle as long as the result side keeps taking transactions; a stalled result holds the
// input register, and input ready drops only once both registers are full.

module length_encoded_int_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lei_byte_if.sink      i_in_chan,
    lei_result_if.source  o_out_chan
);

    lei_pkg::t_stage w_stage;
    logic            w_take;

    lei_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_chan (i_in_chan),
        .i_take    (w_take),
        .o_stage   (w_stage)
    );

    lei_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (w_stage),
        .o_take     (w_take),
        .o_out_chan (o_out_chan)
    );

    a_value_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_chan.valid && (o_out_chan.status != lei_pkg::ST_OK))
            |-> (o_out_chan.value == 64'd0))
        else $error("Non-ok result carries a nonzero value.");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_chan.valid |-> ((o_out_chan.encoded_length >= 4'd1)
            && (o_out_chan.encoded_length <= 4'd9)))
        else $error("Encoded length out of range.");

    a_marker_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_chan.valid && ((o_out_chan.status == lei_pkg::ST_NULL)
            || (o_out_chan.status == lei_pkg::ST_ERR)))
            |-> (o_out_chan.encoded_length == 4'd1))
        else $error("Marker result with length other than one.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_chan.valid)
        else $error("Result valid right after reset.");

endmodule
